// ----- hdl/sdm_pkg.sv -----
// shared types and constants for the signed divide and modulo pipeline
`timescale 1ns / 1ps

package sdm_pkg;

	// operand width and pipeline depth
	localparam int DataW   = 32;
	localparam int Steps   = DataW;
	localparam int Latency = Steps + 2;

	// operation codes carried in func
	localparam logic FUNC_QUO = 1'b0;
	localparam logic FUNC_REM = 1'b1;

	// one request
	typedef struct packed {
		logic                    func;
		logic signed [DataW-1:0] dividend;
		logic signed [DataW-1:0] divisor;
	} sdm_req_t;

	// one result
	typedef struct packed {
		logic signed [DataW-1:0] result;
		logic                    error;
	} sdm_rsp_t;

	// work carried between stages
	typedef struct packed {
		logic             func;
		logic             err;
		logic             q_neg;
		logic             r_neg;
		logic [DataW-1:0] rem;
		logic [DataW-1:0] quo;
		logic [DataW-1:0] dsr;
	} sdm_stage_t;

endpackage

// ----- hdl/sdm_prep.sv -----
// input stage: zero check, signs and operand magnitudes
`timescale 1ns / 1ps

module sdm_prep import sdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  sdm_req_t   req,
	output logic       vld_out,
	output sdm_stage_t data_out
);

	logic             a_neg;
	logic             b_neg;
	logic [DataW-1:0] mag_a;
	logic [DataW-1:0] mag_b;
	logic             vld_s1;
	sdm_stage_t       data_s1;

	// magnitudes as unsigned, the most negative value maps to itself
	always_comb begin
		a_neg = req.dividend[DataW-1];
		b_neg = req.divisor[DataW-1];
		mag_a = a_neg ? ({DataW{1'b0}} - req.dividend) : req.dividend;
		mag_b = b_neg ? ({DataW{1'b0}} - req.divisor) : req.divisor;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	// payload, remainder starts empty and the dividend shifts out of quo
	always_ff @(posedge clk) begin
		data_s1.func  <= req.func;
		data_s1.err   <= (req.divisor == '0);
		data_s1.q_neg <= a_neg ^ b_neg;
		data_s1.r_neg <= a_neg;
		data_s1.rem   <= '0;
		data_s1.quo   <= mag_a;
		data_s1.dsr   <= mag_b;
	end

	assign vld_out  = vld_s1;
	assign data_out = data_s1;

endmodule

// ----- hdl/sdm_step.sv -----
// one restoring division step, one quotient bit per stage
`timescale 1ns / 1ps

module sdm_step import sdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  sdm_stage_t data_in,
	output logic       vld_out,
	output sdm_stage_t data_out
);

	logic [DataW:0]   rem_sh;
	logic [DataW:0]   trial;
	logic             q_bit;
	logic [DataW-1:0] rem_nx;
	logic             vld_s1;
	sdm_stage_t       data_s1;

	// shift in the next dividend bit and try the subtract
	always_comb begin
		rem_sh = {data_in.rem, data_in.quo[DataW-1]};
		trial  = rem_sh - {1'b0, data_in.dsr};
		q_bit  = ~trial[DataW];
		rem_nx = q_bit ? trial[DataW-1:0] : rem_sh[DataW-1:0];
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		data_s1.func  <= data_in.func;
		data_s1.err   <= data_in.err;
		data_s1.q_neg <= data_in.q_neg;
		data_s1.r_neg <= data_in.r_neg;
		data_s1.rem   <= rem_nx;
		data_s1.quo   <= {data_in.quo[DataW-2:0], q_bit};
		data_s1.dsr   <= data_in.dsr;
	end

	assign vld_out  = vld_s1;
	assign data_out = data_s1;

endmodule

// ----- hdl/sdm_post.sv -----
// output stage: sign restore, select and divide-by-zero override
`timescale 1ns / 1ps

module sdm_post import sdm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld,
	input  sdm_stage_t data_in,
	output logic       vld_out,
	output sdm_rsp_t   rsp_out
);

	logic [DataW-1:0] quo_sgn;
	logic [DataW-1:0] rem_sgn;
	sdm_rsp_t         rsp_nx;
	logic             vld_s1;
	sdm_rsp_t         rsp_s1;

	// quotient sign from both operands, remainder sign from the dividend
	always_comb begin
		quo_sgn = data_in.q_neg ? ({DataW{1'b0}} - data_in.quo) : data_in.quo;
		rem_sgn = data_in.r_neg ? ({DataW{1'b0}} - data_in.rem) : data_in.rem;
		rsp_nx.error = data_in.err;
		if (data_in.err) begin
			rsp_nx.result = '0;
		end else if (data_in.func == FUNC_REM) begin
			rsp_nx.result = rem_sgn;
		end else begin
			rsp_nx.result = quo_sgn;
		end
	end

	// strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		rsp_s1 <= rsp_nx;
	end

	assign vld_out = vld_s1;
	assign rsp_out = rsp_s1;

endmodule

// ----- hdl/signed_divide_modulo.sv -----
// top level of the pipelined signed 32-bit divide and modulo unit
//
//  channel   ports               handshake
//  request   start, cmd          taken when start is high and busy is low
//  result    done, res           one-cycle strobe, no back-pressure
//
// one request per cycle; each result passes through a sign and magnitude
// register, 32 restoring steps of one quotient bit each, and a sign restore
// and select register. the subtract in each step sets the clock period.
// reset clears only the valid bits. busy stays low, the pipeline never
// stalls since the receiver always takes the strobe.
`timescale 1ns / 1ps

module signed_divide_modulo import sdm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  sdm_req_t cmd,
	output logic     done,
	output sdm_rsp_t res
);

	logic       vld [0:Steps];
	sdm_stage_t stg [0:Steps];

	// never stalls
	assign busy = 1'b0;

	// signs and magnitudes
	sdm_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (start & ~busy),
		.req      (cmd),
		.vld_out  (vld[0]),
		.data_out (stg[0])
	);

	// chain of division steps
	for (genvar i = 0; i < Steps; i++) begin : g_step
		sdm_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.vld      (vld[i]),
			.data_in  (stg[i]),
			.vld_out  (vld[i+1]),
			.data_out (stg[i+1])
		);
	end

	// sign restore and select
	sdm_post u_post (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld[Steps]),
		.data_in (stg[Steps]),
		.vld_out (done),
		.rsp_out (res)
	);

endmodule

// ----- hdl/sdm_check.sv -----
// port-level checks for the signed divide and modulo unit, bound to the top
`timescale 1ns / 1ps

module sdm_check import sdm_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input sdm_req_t cmd,
	input logic     done,
	input sdm_rsp_t res
);

	// every accepted request gives a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##Latency done)
		else $error("request without result at fixed latency");

	// no result without a request at the fixed latency before
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, Latency))
		else $error("result without matching request");

	// error flag follows a zero divisor and forces the result to zero
	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.error == ($past(cmd.divisor, Latency) == '0)) &&
			(!res.error || res.result == '0))
		else $error("divide-by-zero handling wrong");

	// quotient by one returns the dividend
	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(cmd.func, Latency) == FUNC_QUO &&
			$past(cmd.divisor, Latency) == 32'sd1
		|-> res.result == $past(cmd.dividend, Latency))
		else $error("quotient by one differs from dividend");

endmodule

bind signed_divide_modulo sdm_check u_sdm_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.res    (res)
);

// ----- bench/sdm_checker.sv -----
// checker for the signed divide and modulo unit: predicts each result and compares it
`timescale 1ns / 1ps

module sdm_checker import sdm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  sdm_req_t cmd,
	input  logic     done,
	input  sdm_rsp_t res,
	output int       fails,
	output int       pending
);

	// results owed by the unit, oldest first
	sdm_rsp_t results_due[$];

	// truncated quotient or dividend-signed remainder, zero divisor flagged
	function automatic sdm_rsp_t divmod_of(input sdm_req_t r);
		logic             neg_a;
		logic             neg_b;
		logic [DataW-1:0] mag_a;
		logic [DataW-1:0] mag_b;
		logic [DataW-1:0] mag_q;
		logic [DataW-1:0] mag_r;
		logic [DataW-1:0] quo;
		logic [DataW-1:0] rem;
		sdm_rsp_t         o;
		o = '0;
		if (r.divisor == '0) begin
			o.error = 1'b1;
		end else begin
			neg_a = r.dividend[DataW-1];
			neg_b = r.divisor[DataW-1];
			// magnitudes as unsigned, the most negative value maps to 2^31
			mag_a = neg_a ? ('0 - $unsigned(r.dividend)) : $unsigned(r.dividend);
			mag_b = neg_b ? ('0 - $unsigned(r.divisor)) : $unsigned(r.divisor);
			mag_q = mag_a / mag_b;
			mag_r = mag_a % mag_b;
			quo = (neg_a != neg_b) ? ('0 - mag_q) : mag_q;
			rem = neg_a ? ('0 - mag_r) : mag_r;
			o.result = (r.func == FUNC_REM) ? rem : quo;
		end
		return o;
	endfunction

	// queue each accepted request, then compare any result against the oldest
	always @(posedge clk or negedge arst_n) begin
		sdm_rsp_t want;
		if (!arst_n) begin
			results_due.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			if (start && !busy)
				results_due.push_back(divmod_of(cmd));
			if (done) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result %h error %b", $time, res.result, res.error);
					fails <= fails + 1;
				end else begin
					want = results_due.pop_front();
					if (res.result !== want.result || res.error !== want.error) begin
						$display("%0t: result expected %h got %h, error expected %b got %b",
							$time, want.result, res.result, want.error, res.error);
						fails <= fails + 1;
					end
				end
			end
			pending <= results_due.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// testbench top for the signed divide and modulo unit: stimulus and verdict
`timescale 1ns / 1ps

module tb;
	import sdm_pkg::*;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	sdm_req_t cmd;
	sdm_rsp_t res;
	int       fails;
	int       pending;

	// operand pairs for the directed part, each sent with both operations
	localparam logic [31:0] DirA[12] = '{
		32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
		32'h8000_0000, 32'h7fff_ffff, 32'h0000_0007, 32'h8000_0000,
		32'hffff_fff9, 32'h0000_0007, 32'hffff_fff9, 32'h0000_0000};
	localparam logic [31:0] DirB[12] = '{
		32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0000_0001,
		32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000,
		32'h0000_0002, 32'hffff_fffe, 32'hffff_fffe, 32'hffff_fffb};

	// sender idle percentage per random phase
	localparam int IdlePct[4] = '{0, 45, 23, 0};
	localparam int PhaseItems = 412;

	signed_divide_modulo dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	sdm_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.done    (done),
		.res     (res),
		.fails   (fails),
		.pending (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mix of full-range, small, boundary and scaled operands
	function automatic logic [31:0] pick_operand();
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = $urandom_range(40) - 20;
			6: begin
				case ($urandom_range(4))
					0: v = 32'h0000_0000;
					1: v = 32'h0000_0001;
					2: v = 32'hffff_ffff;
					3: v = 32'h8000_0000;
					default: v = 32'h7fff_ffff;
				endcase
			end
			default: begin
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1))
					v = '0 - v;
			end
		endcase
		return v;
	endfunction

	// offer one request, idling first at random, and hold it until taken
	task automatic send_request(input sdm_req_t r, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// stop sending until every owed result has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		sdm_req_t r;
		arst_n = 1'b0;
		start  <= 1'b0;
		cmd    <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero divisor, most negative over minus one, signs
		for (int i = 0; i < 12; i++) begin
			for (int f = 0; f < 2; f++) begin
				r.func     = f ? FUNC_REM : FUNC_QUO;
				r.dividend = DirA[i];
				r.divisor  = DirB[i];
				send_request(r, 0);
			end
		end

		// random phases with different sender idling
		for (int p = 0; p < 4; p++) begin
			for (int n = 0; n < PhaseItems; n++) begin
				r.func     = $urandom_range(1) ? FUNC_REM : FUNC_QUO;
				r.dividend = pick_operand();
				r.divisor  = pick_operand();
				send_request(r, IdlePct[p]);
			end
			if (p == 1)
				drain();
		end

		drain();
		repeat (Latency + 4) @(posedge clk);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/sdm_pkg.sv
hdl/sdm_prep.sv
hdl/sdm_step.sv
hdl/sdm_post.sv
hdl/signed_divide_modulo.sv
hdl/sdm_check.sv
bench/sdm_checker.sv
bench/tb.sv
